/* rtl/bira_pkg.sv */
// Shared types and constants for the beat interval rate averager.
// No dependencies; imported by every module of the block.
package bira_pkg;

  localparam int HISTORY_DEPTH = 4;
  localparam int SLOT_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int RATE_W        = 8;
  localparam int SUM_W         = $clog2(HISTORY_DEPTH * 255 + 1);
  localparam int TIME_W        = 32;
  localparam int PROD_W        = TIME_W + RATE_W;
  localparam int DIV_W         = 16;
  localparam int DIV_CNT_W     = $clog2(DIV_W);
  localparam int CFG_IDX_W     = 8;

  localparam logic [DIV_W-1:0]     MS_PER_MINUTE    = 16'd60000;
  localparam logic [RATE_W-1:0]    RATE_SAT         = 8'd255;
  localparam logic [RATE_W-1:0]    LOW_LIMIT_RESET  = 8'd20;
  localparam logic [RATE_W-1:0]    HIGH_LIMIT_RESET = 8'd255;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT   = 8'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_CHECK,
    S_DIV_RATE,
    S_AVG_START,
    S_DIV_AVG,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [TIME_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* rtl/bira_div.sv */
// Restoring divider, one quotient bit per cycle, 16-bit dividend by 32-bit divisor.
// Depends on bira_pkg.
module bira_div import bira_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [TIME_W-1:0]    dvs_r, dvs_nxt;
  logic [DIV_W:0]       trial;
  logic                 fits;

  // remainder never reaches 2^16, so a 17-bit trial is enough
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign fits  = {{(TIME_W-DIV_W-1){1'b0}}, trial} >= dvs_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? DIV_W'(trial - dvs_r[DIV_W:0]) : trial[DIV_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

/* rtl/bira_hist.sv */
// Rate history ring with a running sum of its entries.
// Depends on bira_pkg.
module bira_hist import bira_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [RATE_W-1:0] wr_data,
  output logic [SUM_W-1:0]  sum
);

  logic [RATE_W-1:0] entry_r [HISTORY_DEPTH];
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;

  always_comb begin
    slot_nxt = slot_r;
    sum_nxt  = sum_r;
    if (wr_en) begin
      sum_nxt  = sum_r - SUM_W'(entry_r[slot_r]) + SUM_W'(wr_data);
      slot_nxt = (slot_r == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      sum_r  <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        entry_r[i] <= '0;
      end
    end else begin
      slot_r <= slot_nxt;
      sum_r  <= sum_nxt;
      if (wr_en) begin
        entry_r[slot_r] <= wr_data;
      end
    end
  end

  assign sum = sum_r;

endmodule

/* rtl/beat_interval_rate_averager.sv */
// Beat interval rate averager: top level with sequencer and limit multiplier.
// Depends on bira_pkg, bira_div and bira_hist.
//
// Usage
//   in_*  : one transaction per detected beat, carrying its millisecond timestamp.
//   out_* : one transaction per beat: instant rate (60000/interval, saturated to
//           255), an accept flag, and the truncated mean of the rate history.
//   cfg_* : register writes (index 0 low limit, 1 high limit), always ready;
//           unknown indexes are ignored.
// Sequence
//   States S_MUL_LO and S_MUL_HI form the limit products, then S_CHECK tests
//   them and launches the 16-step divider for the rate. For an accepted beat
//   S_AVG_START updates the ring and S_DIV_AVG takes the mean; every beat ends
//   in S_DONE, which hands the result over, after which the sequencer returns
//   to S_IDLE. in_stall is high from a taken beat until S_IDLE, so a new beat
//   is taken only after the last one is handed over. The rate divide is the
//   longest step.
// Reset
//   Synchronous, active low: previous timestamp, history, slot and held mean
//   clear to zero, limits go to 20 and 255.
// Back-pressure
//   Results sit in an output register; the next beat can be taken while one
//   waits. A finished result holds in the sequencer until the register frees.
module beat_interval_rate_averager import bira_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // beat input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [TIME_W-1:0]    in_beat_time_ms,
  // result output
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [RATE_W-1:0]    out_instant_rate,
  output logic                 out_rate_accepted,
  output logic [RATE_W-1:0]    out_average_rate,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RATE_W-1:0]    cfg_data
);

  seq_state_t state_r, state_nxt;

  logic [RATE_W-1:0] low_limit_r, high_limit_r;
  logic [TIME_W-1:0] prev_time_r, prev_time_nxt;
  logic [TIME_W-1:0] interval_r, interval_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              lo_ok_r, lo_ok_nxt;
  logic              acc_r, acc_nxt;
  logic [RATE_W-1:0] rate_r, rate_nxt;
  logic [RATE_W-1:0] held_avg_r, held_avg_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [RATE_W-1:0] out_rate_r, out_rate_nxt;
  logic              out_acc_r, out_acc_nxt;
  logic [RATE_W-1:0] out_avg_r, out_avg_nxt;

  logic              in_take;
  logic [RATE_W-1:0] mul_op;
  logic [RATE_W-1:0] rate_sat;
  logic              hist_wr;
  logic [SUM_W-1:0]  hist_sum;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  bira_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  bira_hist u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (hist_wr),
    .wr_data (rate_r),
    .sum     (hist_sum)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // one 8x32 multiplier, shared between the two limit products
  assign mul_op   = (state_r == S_MUL_LO) ? low_limit_r : high_limit_r;
  assign rate_sat = (|div_rsp.quotient[DIV_W-1:RATE_W]) ? RATE_SAT
                                                         : div_rsp.quotient[RATE_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    prev_time_nxt = prev_time_r;
    interval_nxt  = interval_r;
    prod_nxt      = prod_r;
    lo_ok_nxt     = lo_ok_r;
    acc_nxt       = acc_r;
    rate_nxt      = rate_r;
    held_avg_nxt  = held_avg_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rate_nxt  = out_rate_r;
    out_acc_nxt   = out_acc_r;
    out_avg_nxt   = out_avg_r;
    hist_wr       = 1'b0;
    div_req       = '{start: 1'b0, dividend: MS_PER_MINUTE, divisor: interval_r};

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          interval_nxt  = in_beat_time_ms - prev_time_r;
          prev_time_nxt = in_beat_time_ms;
          state_nxt     = S_MUL_LO;
        end
      end
      S_MUL_LO: begin
        prod_nxt  = PROD_W'(mul_op) * PROD_W'(interval_r);
        state_nxt = S_MUL_HI;
      end
      S_MUL_HI: begin
        lo_ok_nxt = prod_r < PROD_W'(MS_PER_MINUTE);
        prod_nxt  = PROD_W'(mul_op) * PROD_W'(interval_r);
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        acc_nxt       = lo_ok_r && (prod_r > PROD_W'(MS_PER_MINUTE));
        div_req.start = 1'b1;
        state_nxt     = S_DIV_RATE;
      end
      S_DIV_RATE: begin
        if (div_rsp.done) begin
          rate_nxt  = rate_sat;
          state_nxt = acc_r ? S_AVG_START : S_DONE;
        end
      end
      S_AVG_START: begin
        // history sum updates this cycle; the mean is taken once it has settled
        hist_wr   = 1'b1;
        state_nxt = S_DIV_AVG;
      end
      S_DIV_AVG: begin
        // depth is a power of two, so the mean is a plain shift
        held_avg_nxt = RATE_W'(hist_sum / SUM_W'(HISTORY_DEPTH));
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_rate_nxt  = rate_r;
          out_acc_nxt   = acc_r;
          out_avg_nxt   = held_avg_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      low_limit_r  <= LOW_LIMIT_RESET;
      high_limit_r <= HIGH_LIMIT_RESET;
      prev_time_r  <= '0;
      held_avg_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_time_r <= prev_time_nxt;
      held_avg_r  <= held_avg_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LOW_LIMIT:  low_limit_r  <= cfg_data;
          REG_HIGH_LIMIT: high_limit_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
    interval_r <= interval_nxt;
    prod_r     <= prod_nxt;
    lo_ok_r    <= lo_ok_nxt;
    acc_r      <= acc_nxt;
    rate_r     <= rate_nxt;
    out_rate_r <= out_rate_nxt;
    out_acc_r  <= out_acc_nxt;
    out_avg_r  <= out_avg_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_instant_rate  = out_rate_r;
  assign out_rate_accepted = out_acc_r;
  assign out_average_rate  = out_avg_r;

  // an accepted rate lies within the limits
  a_acc_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rate_accepted |->
      (out_instant_rate >= low_limit_r) && (out_instant_rate < high_limit_r))
    else $error("accepted rate outside limits");

  // the divider only finishes while an item is being worked on
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV_RATE) || (state_r == S_DIV_AVG))
    else $error("divider result outside a divide state");

  // a taken beat closes the input until the item is finished
  a_in_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a beat");

endmodule

/* bench/testbench.sv */
// Self-checking bench for beat_interval_rate_averager: beat timestamps in, rate results out.
// Depends on bira_pkg and the block's RTL. An in-bench predictor tracks the interval,
// the rate limits, the four-entry rate ring and the held mean.
module testbench;
  import bira_pkg::*;

  localparam int HOLD_CYCLES = 400;   // one long receiver hold-off
  localparam int IDLE_LIMIT  = 3000;  // cycles without any transaction before giving up
  localparam int DRAIN_WAIT  = 60;    // well over one item's latency
  localparam int PHASE_BEATS = 60;
  localparam int NUM_FIXED   = 8;     // fixed limit settings, then random ones
  localparam int NUM_PHASES  = 12;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic              accepted;
    logic [RATE_W-1:0] average;
  } beat_result_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports. Every input has a known value from time 0.
  // ---------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [TIME_W-1:0]    in_beat_time_ms = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [RATE_W-1:0]    out_instant_rate;
  logic                 out_rate_accepted;
  logic [RATE_W-1:0]    out_average_rate;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [RATE_W-1:0]    cfg_data = '0;

  always #5 clk = ~clk;

  beat_interval_rate_averager dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_beat_time_ms   (in_beat_time_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_instant_rate  (out_instant_rate),
    .out_rate_accepted (out_rate_accepted),
    .out_average_rate  (out_average_rate),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the limits and of the beat history.
  // ---------------------------------------------------------------------------
  logic [RATE_W-1:0] low_lim  = LOW_LIMIT_RESET;
  logic [RATE_W-1:0] high_lim = HIGH_LIMIT_RESET;
  logic [TIME_W-1:0] last_beat_ms = '0;
  logic [RATE_W-1:0] rate_ring [HISTORY_DEPTH];
  logic [SLOT_W-1:0] ring_slot = '0;
  logic [RATE_W-1:0] mean_rate = '0;

  initial begin
    for (int i = 0; i < HISTORY_DEPTH; i++) rate_ring[i] = '0;
  end

  // Pending beat timestamps (driver side) and predicted results (monitor side).
  logic [TIME_W-1:0] pending_beats [$];
  beat_result_t      expected_results [$];

  // Bookkeeping shared between the edge processes.
  bit tx_took, rx_took;        // transaction seen at the last rising edge
  bit hold_req = 1'b0;         // asks the receiver for one long hold-off
  int tx_wait = 0, tx_burst = 0;
  int rx_wait = 0, rx_burst = 0, hold_left = 0;
  int errors = 0, results_seen = 0, results_accepted = 0, settings_run = 0;
  int idle_cycles = 0;

  // Next rate for a beat at time now; updates the ring when the beat passes.
  function automatic beat_result_t predict_beat(logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] gap_ms;
    logic [TIME_W-1:0] quot;
    logic [PROD_W-1:0] lo_prod, hi_prod;
    logic [SUM_W-1:0]  sum;
    beat_result_t      res;
    gap_ms = now - last_beat_ms;   // wraps modulo 2^32 by width
    last_beat_ms = now;
    if (gap_ms == '0) begin
      res.rate = RATE_SAT;
    end else begin
      quot = TIME_W'(MS_PER_MINUTE) / gap_ms;
      res.rate = (quot > TIME_W'(RATE_SAT)) ? RATE_SAT : quot[RATE_W-1:0];
    end
    // limit test in exact integer form: low*gap < 60000 < high*gap
    lo_prod = PROD_W'(low_lim) * PROD_W'(gap_ms);
    hi_prod = PROD_W'(high_lim) * PROD_W'(gap_ms);
    res.accepted = (lo_prod < PROD_W'(MS_PER_MINUTE)) && (PROD_W'(MS_PER_MINUTE) < hi_prod);
    if (res.accepted) begin
      rate_ring[ring_slot] = res.rate;
      ring_slot = (ring_slot == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : ring_slot + 1'b1;
      sum = '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) sum += SUM_W'(rate_ring[i]);
      mean_rate = RATE_W'(sum / HISTORY_DEPTH);
    end
    res.average = mean_rate;
    return res;
  endfunction

  // Random per-transaction wait, with occasional stretches of none at all.
  function automatic int draw_wait(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  // Mostly plausible heart-beat spacing; the rest probes the limit edges,
  // very short gaps (saturation, zero) and arbitrary 32-bit jumps (wrap).
  function automatic logic [TIME_W-1:0] draw_interval();
    int unsigned pick, k;
    pick = $urandom_range(0, 99);
    k = $urandom_range(1, 255);
    if (pick < 65) return $urandom_range(230, 3100);
    if (pick < 80) return 60000 / k + $urandom_range(0, 2) - 1;
    if (pick < 90) return $urandom_range(0, 240);
    return $urandom();
  endfunction

  // ---------------------------------------------------------------------------
  // Rising edge: sample every handshake, keep the predictor in step, check results.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tx_took = rst_n && in_valid && !in_stall;
    rx_took = rst_n && out_valid && !out_stall;

    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOW_LIMIT:  low_lim  = cfg_data;
        REG_HIGH_LIMIT: high_lim = cfg_data;
        default: ;  // unknown register: block ignores it
      endcase
    end

    if (rx_took) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing pending: rate %0d acc %0d avg %0d",
               out_instant_rate, out_rate_accepted, out_average_rate);
        errors++;
      end else begin
        beat_result_t exp_res;
        exp_res = expected_results.pop_front();
        results_seen++;
        if (exp_res.accepted) results_accepted++;
        if (out_instant_rate !== exp_res.rate) begin
          $error("instant_rate: expected %0d, got %0d", exp_res.rate, out_instant_rate);
          errors++;
        end
        if (out_rate_accepted !== exp_res.accepted) begin
          $error("rate_accepted: expected %0d, got %0d", exp_res.accepted,
                 out_rate_accepted);
          errors++;
        end
        if (out_average_rate !== exp_res.average) begin
          $error("average_rate: expected %0d, got %0d", exp_res.average, out_average_rate);
          errors++;
        end
      end
    end

    if (tx_took) expected_results.push_back(predict_beat(in_beat_time_ms));

    // watchdog: any transaction resets the count
    if (tx_took || rx_took || (cfg_valid && cfg_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("testbench NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: falling edge. A stalled beat holds; after a transaction the next
  // beat goes out after its drawn gap. At most one update of in_valid per edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!(in_valid && !tx_took)) begin
      if (tx_took) tx_wait = draw_wait(tx_burst);
      if (tx_wait > 0 || pending_beats.size() == 0) begin
        if (tx_wait > 0) tx_wait--;
        in_valid <= 1'b0;
      end else begin
        in_valid        <= 1'b1;
        in_beat_time_ms <= pending_beats.pop_front();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: falling edge. Random stall after each result, plus one long
  // hold-off on request so the block backs up and stalls its input.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (rx_took) rx_wait = draw_wait(rx_burst);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0] next_stamp = '0;

  // Fixed limit settings: defaults, both extremes, crossed and equal limits.
  logic [RATE_W-1:0] set_low  [NUM_FIXED] = '{8'd20, 8'd0, 8'd0, 8'd255,
                                              8'd255, 8'd60, 8'd100, 8'd40};
  logic [RATE_W-1:0] set_high [NUM_FIXED] = '{8'd255, 8'd255, 8'd0, 8'd255,
                                              8'd0, 8'd180, 8'd100, 8'd200};

  task automatic queue_beat(input logic [TIME_W-1:0] stamp);
    next_stamp = stamp;
    pending_beats.push_back(stamp);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sender pause: nothing left to send and every predicted result received.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  initial begin : stimulus
    logic [RATE_W-1:0] lo, hi;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed beats under reset limits (20..255).
    queue_beat(32'd0);            // first beat: gap from time 0 is zero
    queue_beat(32'd1000);         // 60 bpm, stored
    queue_beat(32'd1000);         // repeated stamp: zero gap
    queue_beat(32'd1235);         // 235 ms: 255 bpm, fails the upper limit
    queue_beat(32'd1471);         // 236 ms: 254 bpm, stored
    queue_beat(32'd4471);         // 3000 ms: exactly the lower limit, rejected
    queue_beat(32'd7470);         // 2999 ms: 20 bpm, just passes
    queue_beat(32'd67470);        // one minute: 1 bpm
    queue_beat(32'd127471);       // just over a minute: 0 bpm
    queue_beat(32'hFFFF_FD00);    // huge forward jump
    queue_beat(32'hFFFF_FFFF);    // all-ones stamp
    queue_beat(32'h0000_0300);    // wraps past zero: forward gap of 769 ms
    queue_beat(32'h0000_0301);    // 1 ms: saturated rate
    queue_beat(32'h8000_0301);    // half-range jump
    queue_beat(32'h8000_0301 + 32'd800);
    queue_beat(32'h8000_0301 + 32'd1600);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < NUM_FIXED) begin
        lo = set_low[p];
        hi = set_high[p];
      end else begin
        lo = $urandom_range(0, 120);
        hi = $urandom_range(80, 255);
      end
      // an unknown register index first: must leave the limits alone
      write_reg(CFG_IDX_W'($urandom_range(REG_HIGH_LIMIT + 1, 255)), RATE_W'($urandom()));
      write_reg(REG_LOW_LIMIT, lo);
      write_reg(REG_HIGH_LIMIT, hi);
      settings_run++;

      // second setting: receiver holds off while beats keep coming
      if (p == 1) hold_req = 1'b1;
      for (int n = 0; n < PHASE_BEATS; n++) queue_beat(next_stamp + draw_interval());
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    $display("%0d beats checked over %0d limit settings, %0d of them stored in the ring",
             results_seen, settings_run, results_accepted);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
